// ----- design/pmcps_pkg.sv -----
// ----------------------------------------------------------------------------
// pmcps_pkg
// Types and constants shared by the poll scheduler modules.
// ----------------------------------------------------------------------------
package pmcps_pkg;

    localparam int CHANNELS  = 8;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PER_W     = 27;
    localparam int ELAP_W    = 32;
    localparam int MASK_W    = 8;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;
    localparam int DIV_STEPS = ELAP_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [ELAP_W-1:0] elapsed_ms;
        logic              force_req;
    } in_word_t;

    typedef struct packed {
        logic [MASK_W-1:0] due_mask;
        logic [PER_W-1:0]  next_wait_ms;
    } out_word_t;

endpackage

// ----- design/pmcps_mod.sv -----
// ----------------------------------------------------------------------------
// pmcps_mod
// Restoring modulo unit: one quotient bit per cycle, remainder out on done.
// ----------------------------------------------------------------------------
module pmcps_mod (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pmcps_pkg::ELAP_W-1:0] dividend,
    input  logic [pmcps_pkg::PER_W-1:0]  divisor,
    output logic                         done,
    output logic [pmcps_pkg::PER_W-1:0]  remainder
);
    import pmcps_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ELAP_W-1:0]    dvd_reg, dvd_next;
    logic [PER_W-1:0]     dsr_reg, dsr_next;
    logic [PER_W-1:0]     rem_reg, rem_next;
    logic [PER_W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[ELAP_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, subtract when it fits
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = PER_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[PER_W-1:0];
            end
            dvd_next = {dvd_reg[ELAP_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/periodic_multi_channel_poll_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// periodic_multi_channel_poll_scheduler_top
// Bank of periodic countdown channels stepped once per scheduler tick.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one word per tick, elapsed milliseconds and a force flag.
//   out channel : one word per tick, mask of channels that fell due and the
//                 shortest remaining wait over enabled channels.
//   APB port    : period_0..period_7 at byte addresses 0x00..0x1C, 27 bits,
//                 zero disables a channel. Write only while idle.
// Channels are visited one at a time through the remaining-time memory:
//   each channel passes a read state and an evaluate state, plus a run
//   of the shared modulo unit when a late channel needs its lateness
//   reduced modulo the period.
// The next tick is accepted as soon as the channel walk ends, even while
// the result word still waits; a stalled receiver holds that word and the
// walk of the following tick waits at its end until the word is taken.
// Reset clears the periods and remaining times (valid bits, no sweep), so
// the first tick makes every enabled channel due.
// ----------------------------------------------------------------------------
module periodic_multi_channel_poll_scheduler_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pmcps_pkg::in_word_t           in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pmcps_pkg::out_word_t          out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmcps_pkg::PADDR_W-1:0] paddr,
    input  logic [pmcps_pkg::PDATA_W-1:0] pwdata,
    output logic [pmcps_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import pmcps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EVAL = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [ELAP_W-1:0]   elap_reg, elap_next;
    logic                force_reg, force_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic [PER_W-1:0]    best_reg, best_next;
    logic                any_reg, any_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_reg, out_next;

    logic [PER_W-1:0]    per_mem [NUM_REGS];
    logic [NUM_REGS-1:0] per_vld_reg;
    logic [PER_W-1:0]    per_rd_reg;
    logic                per_rd_vld_reg;
    logic [PER_W-1:0]    prd_reg;
    logic                prd_vld_reg;

    logic [PER_W-1:0]    rem_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rem_vld_reg;
    logic [PER_W-1:0]    rem_rd_reg;
    logic                rem_rd_vld_reg;

    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [REG_IDX_W-1:0] ch_addr;
    logic                 rd_en;
    logic                 rem_we;
    logic [PER_W-1:0]     rem_wdata;
    logic [PER_W-1:0]     per_cur;
    logic [PER_W-1:0]     rem_cur;
    logic                 div_start;
    logic                 div_done;
    logic [PER_W-1:0]     div_rem;
    logic [ELAP_W-1:0]    late_raw;
    logic                 in_acc;
    logic                 out_acc;
    logic                 last_ch;

    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign ch_addr = REG_IDX_W'(ch_reg);
    assign pready  = 1'b1;
    assign prdata  = PDATA_W'(prd_vld_reg ? prd_reg : '0);

    assign in_acc  = in_valid & ~in_stall;
    assign out_acc = out_valid_reg & ~out_stall;
    assign last_ch = (ch_reg == CH_W'(CHANNELS - 1));

    assign per_cur  = per_rd_vld_reg ? per_rd_reg : '0;
    assign rem_cur  = rem_rd_vld_reg ? rem_rd_reg : '0;
    assign late_raw = elap_reg - ELAP_W'(rem_cur);

    // period memory: APB write, APB read, sequencer read
    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            per_mem[cfg_idx] <= pwdata[PER_W-1:0];
        end
        if (psel & ~penable)
        begin
            prd_reg <= per_mem[cfg_idx];
        end
        if (rd_en)
        begin
            per_rd_reg <= per_mem[ch_addr];
        end
    end

    // remaining-time memory: read one channel, write it back
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[ch_addr] <= rem_wdata;
        end
        if (rd_en)
        begin
            rem_rd_reg <= rem_mem[ch_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_vld_reg    <= '0;
            per_rd_vld_reg <= 1'b0;
            prd_vld_reg    <= 1'b0;
            rem_vld_reg    <= '0;
            rem_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                per_vld_reg[cfg_idx] <= 1'b1;
            end
            if (psel & ~penable)
            begin
                prd_vld_reg <= per_vld_reg[cfg_idx];
            end
            if (rd_en)
            begin
                per_rd_vld_reg <= per_vld_reg[ch_addr];
                rem_rd_vld_reg <= rem_vld_reg[ch_addr];
            end
            if (rem_we)
            begin
                rem_vld_reg[ch_addr] <= 1'b1;
            end
        end
    end

    pmcps_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (late_raw),
        .divisor   (per_cur),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        elap_next      = elap_reg;
        force_next     = force_reg;
        mask_next      = mask_reg;
        best_next      = best_reg;
        any_next       = any_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rem_we         = 1'b0;
        rem_wdata      = '0;
        div_start      = 1'b0;
        in_stall       = (state_reg != S_IDLE);

        if (out_acc)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    elap_next  = in_data.elapsed_ms;
                    force_next = in_data.force_req;
                    ch_next    = '0;
                    mask_next  = '0;
                    best_next  = '0;
                    any_next   = 1'b0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (per_cur != '0 && !force_reg && ELAP_W'(rem_cur) <= elap_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    if (per_cur != '0)
                    begin
                        rem_we = 1'b1;
                        if (force_reg)
                        begin
                            rem_wdata = per_cur;
                            mask_next[ch_addr] = 1'b1;
                        end
                        else
                        begin
                            rem_wdata = rem_cur - elap_reg[PER_W-1:0];
                        end
                        if (!any_reg || rem_wdata < best_reg)
                        begin
                            best_next = rem_wdata;
                        end
                        any_next = 1'b1;
                    end
                    ch_next    = last_ch ? ch_reg : ch_reg + 1'b1;
                    state_next = last_ch ? S_DONE : S_RD;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rem_we             = 1'b1;
                    rem_wdata          = per_cur - div_rem;
                    mask_next[ch_addr] = 1'b1;
                    if (!any_reg || rem_wdata < best_reg)
                    begin
                        best_next = rem_wdata;
                    end
                    any_next   = 1'b1;
                    ch_next    = last_ch ? ch_reg : ch_reg + 1'b1;
                    state_next = last_ch ? S_DONE : S_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_acc)
                begin
                    out_valid_next        = 1'b1;
                    out_next.due_mask     = mask_reg;
                    out_next.next_wait_ms = best_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elap_reg  <= elap_next;
        force_reg <= force_next;
        mask_reg  <= mask_next;
        best_reg  <= best_next;
        any_reg   <= any_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_done) |-> (div_rem < per_cur))
        else $error("modulo remainder not below period");

    a_walk_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_RD && ch_reg == '0))
        else $error("channel walk did not start at channel zero");

    a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside end of walk");

    a_write_only_when_walking: assert property (@(posedge clk) disable iff (!rst_n)
        rem_we |-> (state_reg == S_EVAL || state_reg == S_DIV))
        else $error("remaining-time write outside channel evaluation");

endmodule
